FILE: src/pal_pkg.sv
// Shared types and constants for the positional array list.
`default_nettype none

package pal_pkg;

   // Fixed field widths
   localparam int OP_W    = 3;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 4;
   localparam int STAT_W  = 2;
   localparam int CNT_W   = 5;
   localparam int CAP_W   = 5;

   // Packed stream widths (whole bytes)
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT      = 3'd0,
      OP_APPEND      = 3'd1,
      OP_REMOVE      = 3'd2,
      OP_SWAP_REMOVE = 3'd3,
      OP_READ        = 3'd4
   } pal_op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_BAD_POS = 2'd2
   } pal_status_type;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic                   apply;
      pal_op_type             op;
      logic [POS_W-1:0]       position;
      logic [CNT_W-1:0]       count;
      logic [VALUE_W-1:0]     value;
      logic [VALUE_W-1:0]     last_value;
   } pal_cmd_type;

endpackage

`default_nettype wire

FILE: src/pal_cell.sv
// One list slot: holds an entry and shifts to or from its neighbors.
`default_nettype none

module pal_cell #(
   parameter int INDEX = 0
) (
   input  logic                      clock,
   input  pal_pkg::pal_cmd_type      cmd,
   input  logic [pal_pkg::VALUE_W-1:0] left_entry,
   input  logic [pal_pkg::VALUE_W-1:0] right_entry,
   output logic [pal_pkg::VALUE_W-1:0] entry,
   output logic [pal_pkg::VALUE_W-1:0] pick_value,
   output logic [pal_pkg::VALUE_W-1:0] last_value
);
   import pal_pkg::*;

   localparam logic [31:0] MyIdx = 32'(INDEX);

   logic [VALUE_W-1:0] entry_ff;
   logic [VALUE_W-1:0] entry_in;
   logic [31:0]        pos_ext;
   logic [31:0]        cnt_ext;

   assign pos_ext = 32'(cmd.position);
   assign cnt_ext = 32'(cmd.count);

   // Slot update for the broadcast operation
   always_comb begin
      entry_in = entry_ff;
      if (cmd.apply) begin
         unique case (cmd.op)
            OP_INSERT: begin
               if (MyIdx == pos_ext) begin
                  entry_in = cmd.value;
               end else if (MyIdx > pos_ext && MyIdx <= cnt_ext) begin
                  entry_in = left_entry;
               end
            end
            OP_APPEND: begin
               if (MyIdx == cnt_ext) begin
                  entry_in = cmd.value;
               end
            end
            OP_REMOVE: begin
               if (MyIdx >= pos_ext && MyIdx + 32'd1 < cnt_ext) begin
                  entry_in = right_entry;
               end
            end
            OP_SWAP_REMOVE: begin
               if (MyIdx == pos_ext) begin
                  entry_in = cmd.last_value;
               end
            end
            default: begin
               entry_in = entry_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // Masked taps, OR-combined at the top
   assign entry      = entry_ff;
   assign pick_value = (MyIdx == pos_ext) ? entry_ff : '0;
   assign last_value = (MyIdx + 32'd1 == cnt_ext) ? entry_ff : '0;

endmodule

`default_nettype wire

FILE: src/positional_array_list.sv
// Top level of the positional array list: control, cell chain, result register.
//
//  Channel  Dir  Handshake             Payload
//  req_     in   req_tvalid/tready     tdata: op, value, position
//  rsp_     out  rsp_tvalid/tready     tdata: status, read_value, count
//  csr_     in   csr_wen               csr_wdata: capacity
//
// One item per cycle when not stalled: the cell chain updates every slot in the
// accept cycle, and the result shows the cycle after, from the output register.
// A new item is taken while the result register is empty or being drained.
// Reset clears the count and the result valid and sets capacity to 16;
// entry contents are undefined until written.
`default_nettype none

module positional_array_list #(
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // op [2:0], value [34:3], position [38:35], zero pad [39]
   input  logic [pal_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // status [1:0], read_value [33:2], count [38:34], zero pad [39]
   output logic [pal_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_wen,
   input  logic [pal_pkg::CAP_W-1:0]        csr_wdata
);
   import pal_pkg::*;

   logic [CAP_W-1:0]      capacity_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   pal_op_type            req_op;
   logic [VALUE_W-1:0]    req_value;
   logic [POS_W-1:0]      req_pos;
   logic                  accept;
   logic                  is_full;
   logic [31:0]           limit;
   pal_status_type        status;
   logic                  modify;
   logic [VALUE_W-1:0]    read_value;
   pal_cmd_type           cmd;

   logic [VALUE_W-1:0]    cell_entry [DEPTH];
   logic [VALUE_W-1:0]    cell_pick  [DEPTH];
   logic [VALUE_W-1:0]    cell_last  [DEPTH];
   logic [VALUE_W-1:0]    pick_value;
   logic [VALUE_W-1:0]    last_value;

   // Field unpacking
   assign req_op    = pal_op_type'(req_tdata[2:0]);
   assign req_value = req_tdata[34:3];
   assign req_pos   = req_tdata[38:35];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Effective limit is min(capacity, DEPTH)
   assign limit   = (32'(capacity_ff) < 32'(DEPTH)) ? 32'(capacity_ff) : 32'(DEPTH);
   assign is_full = 32'(count_ff) >= limit;

   // OR-combine the masked taps of all cells
   always_comb begin
      pick_value = '0;
      last_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         pick_value = pick_value | cell_pick[i];
         last_value = last_value | cell_last[i];
      end
   end

   // Status, count and read data for the current item
   always_comb begin
      status     = ST_OK;
      modify     = 1'b0;
      count_in   = count_ff;
      read_value = '0;
      unique case (req_op)
         OP_INSERT: begin
            if (is_full) begin
               status = ST_FULL;
            end else if (5'(req_pos) > count_ff) begin
               status = ST_BAD_POS;
            end else begin
               modify   = 1'b1;
               count_in = count_ff + 5'd1;
            end
         end
         OP_APPEND: begin
            if (is_full) begin
               status = ST_FULL;
            end else begin
               modify   = 1'b1;
               count_in = count_ff + 5'd1;
            end
         end
         OP_REMOVE, OP_SWAP_REMOVE: begin
            if (5'(req_pos) >= count_ff) begin
               status = ST_BAD_POS;
            end else begin
               modify     = 1'b1;
               read_value = pick_value;
               count_in   = count_ff - 5'd1;
            end
         end
         OP_READ: begin
            if (5'(req_pos) >= count_ff) begin
               status = ST_BAD_POS;
            end else begin
               read_value = pick_value;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   assign cmd.apply      = accept && modify;
   assign cmd.op         = req_op;
   assign cmd.position   = req_pos;
   assign cmd.count      = count_ff;
   assign cmd.value      = req_value;
   assign cmd.last_value = last_value;

   // Cell chain
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [VALUE_W-1:0] left_entry;
      logic [VALUE_W-1:0] right_entry;
      if (g == 0) begin : g_first
         assign left_entry = '0;
      end else begin : g_mid_l
         assign left_entry = cell_entry[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_mid_r
         assign right_entry = cell_entry[g+1];
      end
      pal_cell #(
         .INDEX(g)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_entry (left_entry),
         .right_entry(right_entry),
         .entry      (cell_entry[g]),
         .pick_value (cell_pick[g]),
         .last_value (cell_last[g])
      );
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            capacity_ff <= csr_wdata;
         end
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= {1'b0, count_in, read_value, status};
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(DEPTH))
      else $error("entry count exceeds depth");

   a_grow_by_one: assert property (@(posedge clock) disable iff (reset)
      (accept && status == ST_OK && (req_op == OP_INSERT || req_op == OP_APPEND))
      |=> count_ff == $past(count_ff) + 5'd1)
      else $error("successful insert did not grow the list by one");

   a_fail_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (accept && status != ST_OK) |=> $stable(count_ff))
      else $error("failed item changed the count");

   a_rsp_count_matches: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_tvalid && rsp_tdata[38:34] == count_ff))
      else $error("reported count differs from list count");
`endif

endmodule

`default_nettype wire

FILE: sim/positional_array_list_tb.sv
// Testbench for positional_array_list: directed and random list operations checked against a shadow list.
`default_nettype none

module positional_array_list_tb;
   import pal_pkg::*;

   localparam int LIST_DEPTH  = 16;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_ITEMS = 150;
   localparam int PRINT_LIMIT = 40;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   position;
   } list_req_type;

   typedef struct {
      pal_status_type     status;
      logic [VALUE_W-1:0] read_value;
      logic [CNT_W-1:0]   count;
   } list_rsp_type;

   logic                    clock;
   logic                    reset = 1'b1;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic                    csr_wen = 1'b0;
   logic [CAP_W-1:0]        csr_wdata = '0;

   positional_array_list #(.DEPTH(LIST_DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   // Shadow list kept by the monitor
   logic [VALUE_W-1:0] shadow_entries [LIST_DEPTH];
   int unsigned        shadow_count    = 0;
   int unsigned        shadow_capacity = CAP_RESET;

   list_req_type pending_items [$];
   list_rsp_type expected_results [$];

   int  queued_total   = 0;
   int  accepted_total = 0;
   int  checked_total  = 0;
   int  mismatches     = 0;
   int  quiet_cycles   = 0;
   int  status_seen [3] = '{0, 0, 0};
   int  capacity_writes = 0;
   bit  idle_on   = 1'b0;
   bit  req_taken = 1'b0;
   int  req_gap   = 0;
   int  rsp_stall = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Mismatch report: one line each, printing capped
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("ERROR at %0t result %0d: %s got 0x%0h want 0x%0h",
                  $time, checked_total, what, got, want);
   endtask

   // Apply one list operation to the shadow list and return its result
   task automatic apply_list_op(input list_req_type req, output list_rsp_type rsp);
      int unsigned limit;
      int unsigned n;
      int unsigned p;
      limit = (shadow_capacity < LIST_DEPTH) ? shadow_capacity : LIST_DEPTH;
      n = shadow_count;
      p = req.position;
      rsp.status = ST_OK;
      rsp.read_value = '0;
      case (req.op)
         OP_INSERT: begin
            if (n >= limit) begin
               rsp.status = ST_FULL;
            end else if (p > n) begin
               rsp.status = ST_BAD_POS;
            end else begin
               for (int i = n; i > p; i--)
                  shadow_entries[i] = shadow_entries[i-1];
               shadow_entries[p] = req.value;
               n++;
            end
         end
         OP_APPEND: begin
            if (n >= limit) begin
               rsp.status = ST_FULL;
            end else begin
               shadow_entries[n] = req.value;
               n++;
            end
         end
         OP_REMOVE: begin
            if (p >= n) begin
               rsp.status = ST_BAD_POS;
            end else begin
               rsp.read_value = shadow_entries[p];
               for (int i = p; i + 1 < n; i++)
                  shadow_entries[i] = shadow_entries[i+1];
               n--;
            end
         end
         OP_SWAP_REMOVE: begin
            if (p >= n) begin
               rsp.status = ST_BAD_POS;
            end else begin
               rsp.read_value = shadow_entries[p];
               shadow_entries[p] = shadow_entries[n-1];
               n--;
            end
         end
         OP_READ: begin
            if (p >= n)
               rsp.status = ST_BAD_POS;
            else
               rsp.read_value = shadow_entries[p];
         end
         default: ;   // unknown ops leave the list alone
      endcase
      shadow_count = n;
      rsp.count = n[CNT_W-1:0];
   endtask

   // Gap after an item: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      if (!idle_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Request driver, fed from the pending queue
   always @(negedge clock) begin : drive_requests
      list_req_type item;
      if (!reset && (!req_tvalid || req_taken)) begin
         if (req_gap > 0) begin
            req_gap = req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            item = pending_items.pop_front();
            req_tdata  <= {1'b0, item.position, item.value, item.op};
            req_tvalid <= 1'b1;
            req_gap = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response back-pressure: random stalls with an occasional long one
   always @(negedge clock) begin : drive_response_ready
      if (rsp_stall > 0) begin
         rsp_stall = rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if (!idle_on) begin
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
         rsp_stall = $urandom_range(8, 40);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) < 75);
      end
   end

   // Monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin : monitor
      list_req_type req;
      list_rsp_type want;
      logic [STAT_W-1:0]  got_status;
      logic [VALUE_W-1:0] got_value;
      logic [CNT_W-1:0]   got_count;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (csr_wen)
            shadow_capacity = csr_wdata;
         if (req_tvalid && req_tready) begin
            req.op       = req_tdata[2:0];
            req.value    = req_tdata[34:3];
            req.position = req_tdata[38:35];
            apply_list_op(req, want);
            expected_results.push_back(want);
            accepted_total++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got_status = rsp_tdata[1:0];
            got_value  = rsp_tdata[33:2];
            got_count  = rsp_tdata[38:34];
            checked_total++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result, status", got_status, '0);
            end else begin
               want = expected_results.pop_front();
               if (got_status != want.status)
                  report_mismatch("status", got_status, want.status);
               if (got_value != want.read_value)
                  report_mismatch("read_value", got_value, want.read_value);
               if (got_count != want.count)
                  report_mismatch("count", got_count, want.count);
               if (want.status <= ST_BAD_POS)
                  status_seen[want.status]++;
            end
         end
         // Watchdog on cycles without any handshake
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("Timeout after %0d idle cycles", quiet_cycles);
               $display("Mismatches found");
               $finish;
            end
         end
      end
   end

   task automatic queue_item(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                             logic [POS_W-1:0] position);
      list_req_type item;
      item.op = op;
      item.value = value;
      item.position = position;
      pending_items.push_back(item);
      queued_total++;
   endtask

   // Wait until every queued item is accepted and answered, then settle
   task automatic drain_list();
      while (accepted_total != queued_total || expected_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] cap);
      drain_list();
      csr_wdata <= cap;
      csr_wen   <= 1'b1;
      @(negedge clock);
      csr_wen   <= 1'b0;
      capacity_writes++;
      @(negedge clock);
   endtask

   // Random value with extremes mixed in
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Random phase: bursts that grow or shrink the list, plus some noise
   task automatic queue_random_phase(int items, int unsigned cap);
      int unsigned limit;
      int  burst_left;
      bit  growing;
      int  r;
      logic [OP_W-1:0] op;
      logic [POS_W-1:0] pos;
      limit = (cap == 0) ? LIST_DEPTH : ((cap < LIST_DEPTH) ? cap : LIST_DEPTH);
      burst_left = 0;
      growing = 1'b1;
      for (int k = 0; k < items; k++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(8, 40);
            growing = $urandom_range(0, 1);
         end
         burst_left--;
         r = $urandom_range(0, 99);
         pos = $urandom_range(0, limit - 1);
         if (r < 10) begin
            op  = $urandom_range(0, 7);
            pos = $urandom_range(0, 15);
         end else if (growing) begin
            if (r < 50)      op = OP_INSERT;
            else if (r < 80) op = OP_APPEND;
            else if (r < 88) op = OP_READ;
            else if (r < 94) op = OP_REMOVE;
            else             op = OP_SWAP_REMOVE;
         end else begin
            if (r < 25)      op = OP_INSERT;
            else if (r < 35) op = OP_APPEND;
            else if (r < 60) op = OP_REMOVE;
            else if (r < 85) op = OP_SWAP_REMOVE;
            else             op = OP_READ;
         end
         queue_item(op, pick_value(), pos);
      end
   endtask

   initial begin : stimulus
      int unsigned caps [8];
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty list, edge values, shifts, swap-removes, unknown ops
      queue_item(OP_READ, 32'h1234_5678, 4'd0);
      queue_item(OP_REMOVE, 32'h0, 4'd0);
      queue_item(OP_SWAP_REMOVE, 32'h0, 4'd15);
      queue_item(OP_INSERT, 32'hDEAD_BEEF, 4'd1);
      queue_item(OP_INSERT, 32'h7FFF_FFFF, 4'd0);
      queue_item(OP_APPEND, 32'h8000_0000, 4'd0);
      queue_item(OP_APPEND, 32'h0000_0000, 4'd7);
      queue_item(OP_APPEND, 32'hFFFF_FFFF, 4'd15);
      queue_item(OP_INSERT, 32'h5555_5555, 4'd4);   // insert at the end
      queue_item(OP_INSERT, 32'hAAAA_AAAA, 4'd2);   // insert in the middle
      queue_item(OP_READ, 32'h0, 4'd5);
      queue_item(OP_READ, 32'h0, 4'd6);             // one past the end
      queue_item(OP_REMOVE, 32'h0, 4'd0);
      queue_item(OP_SWAP_REMOVE, 32'h0, 4'd1);
      queue_item(OP_SWAP_REMOVE, 32'h0, 4'd3);      // last entry
      queue_item(3'd5, 32'hFFFF_FFFF, 4'd15);
      queue_item(3'd6, 32'h0, 4'd0);
      queue_item(3'd7, 32'hA5A5_A5A5, 4'd10);

      // Capacity below the current count: adds report full, the rest works
      write_capacity(5'd1);
      queue_item(OP_APPEND, 32'h0F0F_0F0F, 4'd0);
      queue_item(OP_INSERT, 32'hF0F0_F0F0, 4'd9);   // full wins over bad position
      queue_item(OP_READ, 32'h0, 4'd2);

      // Capacity zero: always full, removes and reads still work
      write_capacity(5'd0);
      queue_item(OP_INSERT, 32'h1, 4'd0);
      queue_item(OP_REMOVE, 32'h0, 4'd0);
      queue_item(OP_READ, 32'h0, 4'd0);

      // Random phases across capacity settings, extremes included
      caps = '{16, 31, 1, 2, $urandom_range(3, 15), 0, 17, $urandom_range(1, 31)};
      foreach (caps[k]) begin
         write_capacity(caps[k][CAP_W-1:0]);
         idle_on = (k % 4 != 1);
         queue_random_phase(PHASE_ITEMS, caps[k]);
      end

      drain_list();
      repeat (6) @(negedge clock);
      if (expected_results.size() != 0)
         report_mismatch("results never returned", expected_results.size(), 0);
      $display("Checked %0d results over %0d capacity writes", checked_total,
               capacity_writes);
      $display("Status mix: %0d ok, %0d full, %0d bad position", status_seen[ST_OK],
               status_seen[ST_FULL], status_seen[ST_BAD_POS]);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
